/* sv/tgr_pkg.sv */
// ----------------------------------------------------------------------------
// tgr_pkg
// Shared types and constants for the text glyph renderer.
// ----------------------------------------------------------------------------
package tgr_pkg;

	localparam int SCREEN_WIDTH  = 128;
	localparam int SCREEN_HEIGHT = 64;
	localparam int GLYPH_COUNT   = 256;

	localparam int GLYPH_COLS  = 5;
	localparam int CELL_COLS   = 6;
	localparam int CELL_ROWS   = 8;
	localparam int STORE_DEPTH = GLYPH_COUNT * GLYPH_COLS;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	// field widths
	localparam int ACTION_W = 2;
	localparam int CODE_W   = 8;
	localparam int INDEX_W  = 11;
	localparam int BYTE_W   = 8;
	localparam int COORD_W  = 16;
	localparam int SIZE_W   = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	// action codes
	localparam logic [ACTION_W-1:0] ACT_PRINT  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_CURSOR = 2'd2;

	// control characters
	localparam logic [CODE_W-1:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [CODE_W-1:0] CHAR_RETURN  = 8'h0D;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TEXT_SIZE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TEXT_WRAP = 1'd1;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] data;
	} font_wr_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} font_rd_t;

endpackage

/* sv/tgr_if.sv */
// ----------------------------------------------------------------------------
// tgr_in_if / tgr_out_if
// Valid/ready channels for input items and cell commands.
// ----------------------------------------------------------------------------
interface tgr_in_if;
	logic                                 valid;
	logic                                 ready;
	logic [tgr_pkg::ACTION_W-1:0]         action;
	logic [tgr_pkg::CODE_W-1:0]           char_code;
	logic [tgr_pkg::INDEX_W-1:0]          font_index;
	logic [tgr_pkg::BYTE_W-1:0]           font_byte;
	logic signed [tgr_pkg::COORD_W-1:0]   new_cursor_x;
	logic signed [tgr_pkg::COORD_W-1:0]   new_cursor_y;

	modport source (output valid, action, char_code, font_index, font_byte,
		new_cursor_x, new_cursor_y, input ready);
	modport sink (input valid, action, char_code, font_index, font_byte,
		new_cursor_x, new_cursor_y, output ready);
endinterface

interface tgr_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [tgr_pkg::COORD_W-1:0]   cell_x;
	logic signed [tgr_pkg::COORD_W-1:0]   cell_y;
	logic [tgr_pkg::SIZE_W-1:0]           cell_size;
	logic                                 cell_color;
	logic                                 last;

	modport source (output valid, cell_x, cell_y, cell_size, cell_color, last,
		input ready);
	modport sink (input valid, cell_x, cell_y, cell_size, cell_color, last,
		output ready);
endinterface

/* sv/tgr_font_mem.sv */
// ----------------------------------------------------------------------------
// tgr_font_mem
// Font store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tgr_font_mem (
	input  logic                        clk,
	input  tgr_pkg::font_wr_t           wr,
	input  tgr_pkg::font_rd_t           rd,
	output logic [tgr_pkg::BYTE_W-1:0]  rd_data
);
	import tgr_pkg::*;

	logic [BYTE_W-1:0] mem [STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data <= mem[rd.addr];
		end
	end

endmodule

/* sv/tgr_engine.sv */
// ----------------------------------------------------------------------------
// tgr_engine
// Cursor state, item decode and the cell sequencer that walks 6x8 cells,
// fetching each further font column two rows ahead of use.
// ----------------------------------------------------------------------------
module tgr_engine (
	input  logic                        clk,
	input  logic                        arst_n,
	tgr_in_if.sink                      in_ch,
	tgr_out_if.source                   out_ch,
	input  logic [tgr_pkg::SIZE_W-1:0]  text_size,
	input  logic                        text_wrap,
	output tgr_pkg::font_wr_t           font_wr,
	output tgr_pkg::font_rd_t           font_rd,
	input  logic [tgr_pkg::BYTE_W-1:0]  font_data
);
	import tgr_pkg::*;

	localparam int EXT_W = COORD_W + 2;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EMIT = 1'b1;

	logic                state_q;
	logic [COORD_W-1:0]  cursor_col_q, cursor_row_q;
	logic [2:0]          col_q, row_q;
	logic [COORD_W-1:0]  cx_q, cy_q, y0_q;
	logic [INDEX_W-1:0]  base_q;
	logic [BYTE_W-1:0]   bits_q;
	logic                fresh_q, blank_q;

	logic                out_valid_q;
	logic [COORD_W-1:0]  out_x_q, out_y_q;
	logic [SIZE_W-1:0]   out_size_q;
	logic                out_color_q, out_last_q;

	logic                acc, gen, is_print, is_ctrl, draw, wrap_now, code_blank;
	logic [COORD_W-1:0]  sz16, adv_col, row_step;
	logic signed [EXT_W-1:0] x_e, y_e, sz_e, right_e, bottom_e, adv_e, limit_e;
	logic [INDEX_W-1:0]  code_base;
	logic [BYTE_W-1:0]   cur_bits;

	always_comb begin
		acc      = in_ch.valid && in_ch.ready;
		gen      = (state_q == ST_EMIT) && (!out_valid_q || out_ch.ready);
		is_print = in_ch.action == ACT_PRINT;
		is_ctrl  = (in_ch.char_code == CHAR_NEWLINE) || (in_ch.char_code == CHAR_RETURN);

		sz16     = {{(COORD_W-SIZE_W){1'b0}}, text_size};
		sz_e     = {{(EXT_W-SIZE_W){1'b0}}, text_size};
		x_e      = {{2{cursor_col_q[COORD_W-1]}}, cursor_col_q};
		y_e      = {{2{cursor_row_q[COORD_W-1]}}, cursor_row_q};
		right_e  = x_e + EXT_W'(GLYPH_COLS) * sz_e - EXT_W'(1);
		bottom_e = y_e + EXT_W'(CELL_ROWS) * sz_e - EXT_W'(1);
		draw     = !(x_e >= EXT_W'(SCREEN_WIDTH) || y_e >= EXT_W'(SCREEN_HEIGHT) ||
			right_e < 0 || bottom_e < 0);

		adv_col  = cursor_col_q + COORD_W'(6) * sz16;
		row_step = sz16 << 3;
		adv_e    = {{2{adv_col[COORD_W-1]}}, adv_col};
		limit_e  = EXT_W'(SCREEN_WIDTH) - EXT_W'(CELL_COLS) * sz_e;
		wrap_now = text_wrap && (adv_e > limit_e);

		code_base  = {1'b0, in_ch.char_code, 2'b00} + INDEX_W'(in_ch.char_code);
		code_blank = {1'b0, in_ch.char_code} >= 9'(GLYPH_COUNT);

		cur_bits = blank_q ? '0 : (fresh_q ? font_data : bits_q);

		font_wr.en   = acc && (in_ch.action == ACT_LOAD) &&
			({5'b0, in_ch.font_index} < 16'(STORE_DEPTH));
		font_wr.addr = in_ch.font_index[ADDR_W-1:0];
		font_wr.data = in_ch.font_byte;

		// next column is fetched while the second last row of this one goes out
		if (acc) begin
			font_rd.en   = is_print && !is_ctrl && draw && !code_blank;
			font_rd.addr = code_base[ADDR_W-1:0];
		end else begin
			font_rd.en   = gen && (row_q == 3'd6) && (col_q < 3'd4) && !blank_q;
			font_rd.addr = ADDR_W'(base_q + INDEX_W'(col_q) + INDEX_W'(1));
		end
	end

	assign in_ch.ready       = (state_q == ST_IDLE);
	assign out_ch.valid      = out_valid_q;
	assign out_ch.cell_x     = out_x_q;
	assign out_ch.cell_y     = out_y_q;
	assign out_ch.cell_size  = out_size_q;
	assign out_ch.cell_color = out_color_q;
	assign out_ch.last       = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cursor_col_q <= '0;
			cursor_row_q <= '0;
			col_q        <= '0;
			row_q        <= '0;
			fresh_q      <= 1'b0;
			blank_q      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (gen) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end

			if (acc) begin
				unique case (in_ch.action)
					ACT_PRINT: begin
						if (in_ch.char_code == CHAR_NEWLINE) begin
							cursor_row_q <= cursor_row_q + row_step;
							cursor_col_q <= '0;
						end else if (in_ch.char_code != CHAR_RETURN) begin
							if (wrap_now) begin
								cursor_row_q <= cursor_row_q + row_step;
								cursor_col_q <= '0;
							end else begin
								cursor_col_q <= adv_col;
							end
							if (draw) begin
								state_q <= ST_EMIT;
								col_q   <= '0;
								row_q   <= '0;
								fresh_q <= 1'b1;
								blank_q <= code_blank;
							end
						end
					end
					ACT_CURSOR: begin
						cursor_col_q <= in_ch.new_cursor_x;
						cursor_row_q <= in_ch.new_cursor_y;
					end
					default: ;
				endcase
			end

			if (gen) begin
				if (fresh_q) begin
					fresh_q <= 1'b0;
				end
				if (row_q == 3'd7) begin
					row_q <= '0;
					col_q <= col_q + 3'd1;
					// sixth column is always blank
					fresh_q <= col_q < 3'd4;
					if (col_q == 3'd5) begin
						state_q <= ST_IDLE;
					end
				end else begin
					row_q <= row_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			cx_q   <= cursor_col_q;
			cy_q   <= cursor_row_q;
			y0_q   <= cursor_row_q;
			base_q <= code_base;
		end
		if (gen) begin
			out_x_q     <= cx_q;
			out_y_q     <= cy_q;
			out_size_q  <= text_size;
			out_color_q <= cur_bits[row_q];
			out_last_q  <= (col_q == 3'd5) && (row_q == 3'd7);
			if (fresh_q) begin
				bits_q <= font_data;
			end
			if (row_q == 3'd7) begin
				cy_q <= y0_q;
				cx_q <= cx_q + sz16;
				if (col_q == 3'd4) begin
					bits_q <= '0;
				end
			end else begin
				cy_q <= cy_q + sz16;
			end
		end
	end

endmodule

/* sv/text_glyph_renderer.sv */
// ----------------------------------------------------------------------------
// text_glyph_renderer
// Turns characters into square cell commands from a loadable 5x8 font.
// ----------------------------------------------------------------------------
// A visible printed character occupies the block for its 6x8 cells, one cell
// command per cycle while the output is not stalled. The accept cycle issues
// the read of the first font column; each further font column is read from
// the font RAM two rows before it is needed. Stalls on the output hold the
// sequence. Newline, carriage return, off-screen characters, font loads and
// cursor sets emit no cells and leave the block idle. The font RAM has no reset;
// glyphs must be loaded before they are printed. Configuration writes take
// effect on the next cycle and are meant for idle periods only.
module text_glyph_renderer (
	input  logic                           clk,
	input  logic                           arst_n,
	tgr_in_if.sink                         in_ch,
	tgr_out_if.source                      out_ch,
	input  logic                           cfg_we,
	input  logic [tgr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tgr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tgr_pkg::*;

	logic [SIZE_W-1:0] text_size_q;
	logic              text_wrap_q;
	font_wr_t          font_wr;
	font_rd_t          font_rd;
	logic [BYTE_W-1:0] font_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_size_q <= SIZE_W'(1);
			text_wrap_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TEXT_SIZE: text_size_q <= (cfg_data[SIZE_W-1:0] == '0) ?
					SIZE_W'(1) : cfg_data[SIZE_W-1:0];
				REG_TEXT_WRAP: text_wrap_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	tgr_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.text_size (text_size_q),
		.text_wrap (text_wrap_q),
		.font_wr   (font_wr),
		.font_rd   (font_rd),
		.font_data (font_data)
	);

	tgr_font_mem u_font_mem (
		.clk     (clk),
		.wr      (font_wr),
		.rd      (font_rd),
		.rd_data (font_data)
	);

endmodule
